// ===== hdl/ectt_pkg.sv =====
package ectt_pkg;

  localparam int KIND_W         = 4;
  localparam int OBJ_W          = 16;
  localparam int DELAY_IN_W     = 10;
  localparam int MAX_RESULTS    = 16;
  localparam int ENTRIES_DEF    = 16;
  localparam int DELAY_BITS_DEF = 10;

  // Item kind codes.
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              fired;
    logic [KIND_W-1:0] kind;
    logic [OBJ_W-1:0]  object;
    logic              full;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } rbuf_push_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } rbuf_stat_t;

endpackage

// ===== hdl/ectt_mem.sv =====
module ectt_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ectt_rbuf.sv =====
module ectt_rbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  ectt_pkg::rbuf_push_t push,
  input  logic                pop,
  output ectt_pkg::res_t      head,
  output ectt_pkg::rbuf_stat_t stat
);
  import ectt_pkg::*;

  localparam int PTR_W = $clog2(MAX_RESULTS);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  res_t             slots [MAX_RESULTS];
  logic [CNT_W-1:0] wcnt;
  logic [PTR_W-1:0] rd_ptr;

  // Words are all written before the first one is read out, so the
  // write count doubles as the number of words held.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wcnt   <= '0;
      rd_ptr <= '0;
    end else begin
      if (push.push) begin
        wcnt <= wcnt + CNT_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wcnt[PTR_W-1:0]] <= push.res;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.full  = (wcnt == CNT_W'(MAX_RESULTS));
  assign stat.empty = (wcnt == '0);
  assign stat.last  = ((CNT_W'(rd_ptr) + CNT_W'(1)) == wcnt);

endmodule

// ===== hdl/event_coalescing_timer_table.sv =====
// Hold-off timer table for coalescing repeated messages keyed by (msg_kind,
// object_id). An add (kind 0) for a new key takes the lowest free entry and
// fires at once; for a known key it only replaces the reload value and marks
// the entry pending; with no free entry it fires untracked with table_full.
// A tick (kind 1) decrements every live countdown; an entry at zero fires and
// reloads if pending, otherwise it is freed. A tick fires at most 16 words, in
// entry order; a tick that fires nothing returns one word with fired low.
// Every item walks the whole entry memory through its single read port, one
// entry per cycle, and then hands out its result words; one item is handled
// at a time and item_stall stays high until its last word has been taken.
// Entry contents need no clearing pass after reset: valid bits in flip-flops
// gate every entry.
module event_coalescing_timer_table #(
  parameter int ENTRIES    = ectt_pkg::ENTRIES_DEF,
  parameter int DELAY_BITS = ectt_pkg::DELAY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            kind,
  input  logic [ectt_pkg::KIND_W-1:0]     msg_kind,
  input  logic [ectt_pkg::OBJ_W-1:0]      object_id,
  input  logic [ectt_pkg::DELAY_IN_W-1:0] delay_ticks,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            fired,
  output logic [ectt_pkg::KIND_W-1:0]     fired_kind,
  output logic [ectt_pkg::OBJ_W-1:0]      fired_object,
  output logic                            table_full,
  output logic                            table_busy,
  output logic                            last
);
  import ectt_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = KIND_W + OBJ_W + 2 * DELAY_BITS + 1;
  localparam int RL_LO  = 1;
  localparam int CD_LO  = 1 + DELAY_BITS;
  localparam int OBJ_LO = 1 + 2 * DELAY_BITS;
  localparam int KD_LO  = OBJ_LO + OBJ_W;
  localparam logic [DELAY_BITS-1:0] DMAX = '1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  logic [1:0]            state;
  logic                  cur_kind;
  logic [KIND_W-1:0]     cur_kd;
  logic [OBJ_W-1:0]      cur_obj;
  logic [DELAY_BITS-1:0] cur_d;
  logic [IDX_W-1:0]      walk_idx;
  logic                  issuing;
  logic                  s1_v;
  logic [IDX_W-1:0]      s1_idx;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [DELAY_BITS-1:0] hit_cd;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [ENTRIES-1:0]    valid;
  logic [CNT_W-1:0]      vcount;

  logic                  item_acc;
  logic                  res_acc;
  logic [DELAY_BITS-1:0] d_sat;
  logic [WORD_W-1:0]     rdata;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;
  rbuf_push_t            push;
  rbuf_stat_t            stat;
  res_t                  head;
  logic                  free_now;
  logic                  alloc_now;
  logic                  s1_live;
  logic                  s1_end;

  logic [KIND_W-1:0]     r_kd;
  logic [OBJ_W-1:0]      r_obj;
  logic [DELAY_BITS-1:0] r_cd;
  logic [DELAY_BITS-1:0] r_rl;
  logic                  r_pend;

  assign item_acc     = item_valid && !item_stall;
  assign res_acc      = result_valid && !result_stall;
  assign item_stall   = (state != ST_IDLE);
  assign result_valid = (state == ST_DRAIN);

  assign d_sat = (32'(delay_ticks) > 32'(DMAX)) ? DMAX : DELAY_BITS'(delay_ticks);

  assign r_kd   = rdata[KD_LO +: KIND_W];
  assign r_obj  = rdata[OBJ_LO +: OBJ_W];
  assign r_cd   = rdata[CD_LO +: DELAY_BITS];
  assign r_rl   = rdata[RL_LO +: DELAY_BITS];
  assign r_pend = rdata[0];

  assign s1_live = s1_v && valid[s1_idx];
  assign s1_end  = s1_v && (s1_idx == IDX_W'(ENTRIES - 1));

  ectt_mem #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_mem (
    .clk  (clk),
    .raddr(walk_idx),
    .rdata(rdata),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata)
  );

  ectt_rbuf u_rbuf (
    .clk  (clk),
    .rst  (rst),
    .clear(item_acc),
    .push (push),
    .pop  (res_acc),
    .head (head),
    .stat (stat)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_idx;
    mem_wdata = rdata;
    push      = '0;
    free_now  = 1'b0;
    alloc_now = 1'b0;
    unique case (state)
      ST_WALK: begin
        if (cur_kind == KIND_TICK && s1_live) begin
          if (r_cd != '0) begin
            mem_we    = 1'b1;
            mem_wdata = {r_kd, r_obj, r_cd - DELAY_BITS'(1), r_rl, r_pend};
          end else if (r_pend) begin
            // With the result buffer full the entry waits for a later tick.
            if (!stat.full) begin
              mem_we    = 1'b1;
              mem_wdata = {r_kd, r_obj, r_rl, r_rl, 1'b0};
              push.push = 1'b1;
              push.res  = '{fired: 1'b1, kind: r_kd, object: r_obj, full: 1'b0};
            end
          end else begin
            free_now = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (cur_kind == KIND_ADD) begin
          push.push = 1'b1;
          if (hit_found) begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx;
            mem_wdata = {cur_kd, cur_obj, hit_cd, cur_d, 1'b1};
          end else if (free_found) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx;
            mem_wdata = {cur_kd, cur_obj, cur_d, cur_d, 1'b0};
            alloc_now = 1'b1;
            push.res  = '{fired: 1'b1, kind: cur_kd, object: cur_obj, full: 1'b0};
          end else begin
            push.res  = '{fired: 1'b1, kind: cur_kd, object: cur_obj, full: 1'b1};
          end
        end else if (stat.empty) begin
          push.push = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      issuing <= 1'b0;
      s1_v    <= 1'b0;
      valid   <= '0;
      vcount  <= '0;
    end else begin
      s1_v <= issuing;
      unique case (state)
        ST_IDLE: begin
          if (item_acc) begin
            state   <= ST_WALK;
            issuing <= 1'b1;
          end
        end
        ST_WALK: begin
          if (issuing && walk_idx == IDX_W'(ENTRIES - 1)) begin
            issuing <= 1'b0;
          end
          if (s1_end) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (res_acc && stat.last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (free_now) begin
        valid[s1_idx] <= 1'b0;
        vcount        <= vcount - CNT_W'(1);
      end else if (alloc_now) begin
        valid[free_idx] <= 1'b1;
        vcount          <= vcount + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= walk_idx;
    if (item_acc) begin
      cur_kind   <= kind;
      cur_kd     <= msg_kind;
      cur_obj    <= object_id;
      cur_d      <= d_sat;
      walk_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (issuing && walk_idx != IDX_W'(ENTRIES - 1)) begin
        walk_idx <= walk_idx + IDX_W'(1);
      end
      // Key search for an add: first matching live entry, lowest free entry.
      if (state == ST_WALK && cur_kind == KIND_ADD && s1_v) begin
        if (s1_live && !hit_found && r_kd == cur_kd && r_obj == cur_obj) begin
          hit_found <= 1'b1;
          hit_idx   <= s1_idx;
          hit_cd    <= r_cd;
        end
        if (!valid[s1_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= s1_idx;
        end
      end
    end
  end

  assign fired        = head.fired;
  assign fired_kind   = head.kind;
  assign fired_object = head.object;
  assign table_full   = head.full;
  assign table_busy   = (vcount != '0);
  assign last         = stat.last;

  a_vcount: assert property (@(posedge clk) disable iff (rst)
    32'(vcount) == $countones(valid))
    else $error("valid entry count disagrees with valid bits");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !stat.full)
    else $error("result buffer written while full");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    alloc_now |-> !valid[free_idx])
    else $error("allocation into a live entry");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_acc && stat.last) |=> !item_stall)
    else $error("block not ready after last word");

endmodule
